FILE: rtl/i2c_master_bit_engine_unit_macros.svh
// assertion macros for the i2c master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// property checked every clock, off while in reset
`define I2CMBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication, off while in reset
`define I2CMBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/i2cmbe_pkg.sv
// types, codes and constants shared by the i2c master bit engine
`default_nettype none

package i2cmbe_pkg;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WAIT  = 3'd5;

  localparam logic [1:0] ACK_NONE  = 2'd0;
  localparam logic [1:0] ACK_SEND  = 2'd1;
  localparam logic [1:0] ACK_NACK  = 2'd2;
  localparam logic [1:0] ACK_THREE = 2'd3;

  localparam logic [7:0] MSB_MASK         = 8'h80;
  localparam logic [4:0] WRITE_PHASES     = 5'd24;
  localparam logic [4:0] READ_BIT_PHASES  = 5'd16;
  localparam logic [15:0] TPD_RESET       = 16'd1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic [1:0] ack_mode;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] ph;
    logic [7:0] tx;
    logic [1:0] pend;
    logic [7:0] shift;
    logic       sda_in;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       ack;
  } seq_in_t;

  typedef struct packed {
    logic       fin;
    logic       scl;
    logic       sda;
    logic [7:0] shift;
    logic [7:0] rx;
    logic       ack;
  } seq_out_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_master_bit_engine_unit.sv
// top level of the tick driven i2c master bit engine
// path: a tick transaction is held in the input register, then updated into the result register
// throughput: one tick per clock while out_ready_i does not stall the result register, set by the single
//   update step between the input register and the result register
// reset: engine idle, scl and sda released, read byte and ack flag zero,
//   ticks_per_delay one
`default_nettype none

`include "i2c_master_bit_engine_unit_macros.svh"

module i2c_master_bit_engine_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  command_i,
  input  wire  [7:0]  write_data_i,
  input  wire  [1:0]  ack_mode_i,
  input  wire         sda_in_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        scl_out_o,
  output logic        sda_release_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        ack_missing_o,
  output logic        rejected_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i
);
  import i2cmbe_pkg::*;

  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        core_ready;
  res_t        res;
  logic [15:0] tpd_q;

  assign in_item.command    = command_i;
  assign in_item.write_data = write_data_i;
  assign in_item.ack_mode   = ack_mode_i;
  assign in_item.sda_in     = sda_in_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpd_q <= TPD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tpd_q <= cfg_data_i;
    end
  end

  i2cmbe_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (item_valid),
    .item_ready_i (core_ready),
    .item_o       (item)
  );

  i2cmbe_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (core_ready),
    .item_i       (item),
    .tpd_i        (tpd_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign scl_out_o     = res.scl_out;
  assign sda_release_o = res.sda_release;
  assign busy_res_o    = res.busy_res;
  assign done_res_o    = res.done_res;
  assign read_data_o   = res.read_data;
  assign ack_missing_o = res.ack_missing;
  assign rejected_o    = res.rejected;

  // a finishing tick leaves the engine idle
  `I2CMBE_ASSERT_IMPL(a_done_idle, out_valid_o && done_res_o, !busy_res_o, "done while busy")
  // a drop only happens while a command runs, so it is still running or ends now
  `I2CMBE_ASSERT_IMPL(a_rej_busy, out_valid_o && rejected_o, busy_res_o || done_res_o,
    "rejected while idle")
  // input stalls only when its register is full and the result side is stuck
  `I2CMBE_ASSERT_IMPL(a_stall_cause, !in_ready_o, item_valid && !core_ready,
    "input stalled without cause")
  // an idle tick that ends nothing never carries a drop, whatever the lines do
  `I2CMBE_ASSERT(a_idle_lines, !(out_valid_o && !busy_res_o && !done_res_o && !scl_out_o
    && !sda_release_o && rejected_o), "idle result flagged as rejected")

endmodule

`default_nettype wire

FILE: rtl/i2cmbe_in_reg.sv
// input register stage holding one tick item
`default_nettype none

module i2cmbe_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  i2cmbe_pkg::item_t   item_i,
  output logic                item_valid_o,
  input  wire                 item_ready_i,
  output i2cmbe_pkg::item_t   item_o
);
  import i2cmbe_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2cmbe_seq.sv
// line change decoder: what one step of each command does to scl, sda and the sampled data
`default_nettype none

module i2cmbe_seq (
  input  i2cmbe_pkg::seq_in_t  s_i,
  output i2cmbe_pkg::seq_out_t s_o
);
  import i2cmbe_pkg::*;

  logic [8:0] prod;
  logic [2:0] wbit;
  logic [4:0] wsub_full;
  logic [1:0] wsub;
  logic [2:0] rbit;
  logic [4:0] aph;
  logic [7:0] shifted;

  always_comb begin
    // phase / 3 for phases below 24 via multiply by 11, shift by 5
    prod      = {4'd0, s_i.ph} * 9'd11;
    wbit      = prod[7:5];
    wsub_full = s_i.ph - ({1'b0, wbit, 1'b0} + {2'b00, wbit});
    wsub      = wsub_full[1:0];
    rbit      = s_i.ph[3:1];
    aph       = s_i.ph - READ_BIT_PHASES;
    shifted   = {s_i.shift[6:0], s_i.sda_in};

    s_o.fin   = 1'b0;
    s_o.scl   = s_i.scl;
    s_o.sda   = s_i.sda;
    s_o.shift = s_i.shift;
    s_o.rx    = s_i.rx;
    s_o.ack   = s_i.ack;

    case (s_i.op)
      OP_START: begin
        case (s_i.ph)
          5'd0:    s_o.sda = 1'b1;
          5'd1:    s_o.scl = 1'b1;
          5'd2:    s_o.sda = 1'b0;
          5'd3:    s_o.scl = 1'b0;
          default: s_o.fin = 1'b1;
        endcase
      end
      OP_STOP: begin
        if (s_i.ph == 5'd0) begin
          s_o.sda = 1'b0;
          s_o.scl = 1'b1;
        end else begin
          s_o.sda = 1'b1;
          s_o.fin = 1'b1;
        end
      end
      OP_WRITE: begin
        if (s_i.ph >= WRITE_PHASES) begin
          s_o.fin = 1'b1;
        end else begin
          case (wsub)
            2'd0:    s_o.sda = |(s_i.tx & (MSB_MASK >> wbit));
            2'd1:    s_o.scl = 1'b1;
            default: begin
              s_o.scl = 1'b0;
              if (wbit == 3'd7) begin
                s_o.sda = 1'b1;
              end
            end
          endcase
        end
      end
      OP_READ: begin
        if (s_i.ph < READ_BIT_PHASES) begin
          if (!s_i.ph[0]) begin
            // first step lets go of sda so the slave can drive it
            if (s_i.ph == 5'd0) begin
              s_o.sda = 1'b1;
            end
            s_o.scl = 1'b1;
          end else begin
            s_o.shift = shifted;
            s_o.scl   = 1'b0;
            if (rbit == 3'd7) begin
              s_o.rx = shifted;
            end
          end
        end else if (s_i.pend == ACK_NONE) begin
          s_o.fin = 1'b1;
        end else begin
          case (aph)
            5'd0:    s_o.sda = (s_i.pend == ACK_SEND) ? 1'b0 : 1'b1;
            5'd1:    s_o.scl = 1'b1;
            5'd2:    s_o.scl = 1'b0;
            default: begin
              if (s_i.pend == ACK_SEND) begin
                s_o.sda = 1'b1;
              end
              s_o.fin = 1'b1;
            end
          endcase
        end
      end
      OP_WAIT: begin
        case (s_i.ph)
          5'd0:    s_o.sda = 1'b1;
          5'd1:    s_o.scl = 1'b1;
          5'd2: begin
            s_o.ack = s_i.sda_in;
            s_o.scl = 1'b0;
          end
          default: s_o.fin = 1'b1;
        endcase
      end
      default: s_o.fin = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/i2cmbe_core.sv
// engine state, per-tick update and result register
`default_nettype none

module i2cmbe_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  output logic                item_ready_o,
  input  i2cmbe_pkg::item_t   item_i,
  input  wire  [15:0]         tpd_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output i2cmbe_pkg::res_t    res_o
);
  import i2cmbe_pkg::*;

  logic [2:0]  op_q, op_d;
  logic [4:0]  phase_q, phase_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] delay_q, delay_d;
  logic [1:0]  pend_q, pend_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_q, ack_d;
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic        out_valid_q;
  res_t        res_q, res_d;

  logic        advance;
  logic        cmd_ok;
  logic        busy;
  logic [15:0] unit;
  logic [15:0] dec;
  logic [1:0]  am_fix;
  logic        done;
  logic        rej;
  seq_in_t     seq_in;
  seq_out_t    seq_out;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign advance      = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign res_o        = res_q;

  i2cmbe_seq u_seq (
    .s_i (seq_in),
    .s_o (seq_out)
  );

  always_comb begin
    cmd_ok = item_i.command inside {[OP_START:OP_WAIT]};
    busy   = (op_q != OP_NONE);
    unit   = (tpd_i == 16'd0) ? 16'd1 : tpd_i;
    dec    = (delay_q != 16'd0) ? delay_q - 16'd1 : delay_q;
    am_fix = (item_i.ack_mode == ACK_THREE) ? ACK_NACK : item_i.ack_mode;

    // one decoder serves both the accepting step and the later steps
    seq_in.op     = busy ? op_q : item_i.command;
    seq_in.ph     = busy ? phase_q + 5'd1 : 5'd0;
    seq_in.tx     = busy ? tx_q : item_i.write_data;
    seq_in.pend   = busy ? pend_q : am_fix;
    seq_in.shift  = shift_q;
    seq_in.sda_in = item_i.sda_in;
    seq_in.scl    = scl_q;
    seq_in.sda    = sda_q;
    seq_in.rx     = rx_q;
    seq_in.ack    = ack_q;

    op_d    = op_q;
    phase_d = phase_q;
    shift_d = shift_q;
    delay_d = delay_q;
    pend_d  = pend_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    done    = 1'b0;
    rej     = 1'b0;

    if (busy) begin
      rej     = cmd_ok;
      delay_d = dec;
      if (dec == 16'd0) begin
        scl_d   = seq_out.scl;
        sda_d   = seq_out.sda;
        shift_d = seq_out.shift;
        rx_d    = seq_out.rx;
        ack_d   = seq_out.ack;
        if (seq_out.fin) begin
          op_d    = OP_NONE;
          phase_d = 5'd0;
          done    = 1'b1;
        end else begin
          phase_d = seq_in.ph;
          delay_d = unit;
        end
      end
    end else if (cmd_ok) begin
      op_d    = item_i.command;
      tx_d    = item_i.write_data;
      pend_d  = am_fix;
      phase_d = 5'd0;
      scl_d   = seq_out.scl;
      sda_d   = seq_out.sda;
      shift_d = seq_out.shift;
      rx_d    = seq_out.rx;
      ack_d   = seq_out.ack;
      delay_d = unit;
    end

    res_d.scl_out     = scl_d;
    res_d.sda_release = sda_d;
    res_d.busy_res    = (op_d != OP_NONE);
    res_d.done_res    = done;
    res_d.read_data   = rx_d;
    res_d.ack_missing = ack_d;
    res_d.rejected    = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_NONE;
      phase_q     <= 5'd0;
      shift_q     <= 8'd0;
      delay_q     <= 16'd0;
      pend_q      <= ACK_NONE;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      tx_q        <= 8'd0;
      rx_q        <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        op_q    <= op_d;
        phase_q <= phase_d;
        shift_q <= shift_d;
        delay_q <= delay_d;
        pend_q  <= pend_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        ack_q   <= ack_d;
        tx_q    <= tx_d;
        rx_q    <= rx_d;
      end
      if (item_ready_o) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire
